@@ rtl/aalr_pkg.sv @@
// ----------------------------------------------------------------------------
// aalr_pkg
// Shared constants, controller state type and the controller/datapath
// command and status bundles of the antialiased line stepper.
// ----------------------------------------------------------------------------
package aalr_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // command field codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWAP,
        S_ORDER,
        S_DIV,
        S_SLOPE,
        S_LINE
    } t_state;

    typedef struct packed {
        logic capture;
        logic swap;
        logic order;
        logic div_first;
        logic div_step;
        logic set_slope;
        logic advance;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

@@ rtl/aalr_ctrl.sv @@
// ----------------------------------------------------------------------------
// aalr_ctrl
// Sequencer: line setup, slope division steps, column stepping and the
// output register handshake.
// ----------------------------------------------------------------------------
module aalr_ctrl #(
    parameter int FRAC_BITS = aalr_pkg::FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  aalr_pkg::t_dp_status  i_status,
    output aalr_pkg::t_dp_cmd     o_cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    aalr_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_emit, n_emit;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;
    logic              w_take_in;
    logic              w_accept;
    aalr_pkg::t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aalr_pkg::S_IDLE;
            r_cnt       <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_emit     = r_emit;
        w_cmd      = '0;
        w_out_free = !r_out_valid || i_out_ready;
        w_take_in  = ((r_state == aalr_pkg::S_IDLE) || (r_state == aalr_pkg::S_LINE))
                     && (!r_emit || w_out_free);
        w_accept   = i_in_valid && w_take_in;

        // pending column moves into the output register
        w_cmd.load_out = r_emit && w_out_free;
        if (w_cmd.load_out) begin
            n_emit = 1'b0;
        end
        n_out_valid = w_cmd.load_out || (r_out_valid && !i_out_ready);

        case (r_state)
            aalr_pkg::S_IDLE, aalr_pkg::S_LINE: begin
                if ((r_state == aalr_pkg::S_LINE) && i_status.last) begin
                    n_state = aalr_pkg::S_IDLE;
                end
                if (w_accept) begin
                    if (i_command == aalr_pkg::CMD_START) begin
                        w_cmd.capture = 1'b1;
                        n_state       = aalr_pkg::S_SWAP;
                    end else if ((r_state == aalr_pkg::S_LINE) && !i_status.last) begin
                        w_cmd.advance = 1'b1;
                        n_emit        = 1'b1;
                    end
                    // advance with no line running is dropped
                end
            end
            aalr_pkg::S_SWAP: begin
                w_cmd.swap = 1'b1;
                n_state    = aalr_pkg::S_ORDER;
            end
            aalr_pkg::S_ORDER: begin
                w_cmd.order = 1'b1;
                n_cnt       = CNT_W'(FRAC_BITS);
                n_state     = aalr_pkg::S_DIV;
            end
            aalr_pkg::S_DIV: begin
                w_cmd.div_step  = 1'b1;
                w_cmd.div_first = (r_cnt == CNT_W'(FRAC_BITS));
                if (r_cnt == '0) begin
                    n_state = aalr_pkg::S_SLOPE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            aalr_pkg::S_SLOPE: begin
                w_cmd.set_slope = 1'b1;
                n_emit          = 1'b1;
                n_state         = aalr_pkg::S_LINE;
            end
            default: begin
                n_state = aalr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = w_take_in;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`ifndef SYNTHESIS
    // a column waiting behind a stalled output is kept
    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit && r_out_valid && !i_out_ready) |=> r_emit)
        else $error("pending column lost while output stalled");

    // no column is pending while a line is being set up
    a_setup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == aalr_pkg::S_SWAP) || (r_state == aalr_pkg::S_ORDER)
         || (r_state == aalr_pkg::S_DIV)) |-> !r_emit)
        else $error("column pending during line setup");

    // the division ends after its last step
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == aalr_pkg::S_DIV) && (r_cnt == '0)) |=> (r_state == aalr_pkg::S_SLOPE))
        else $error("division did not finish");

    // the first column is queued once the slope is known
    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aalr_pkg::S_SLOPE) |=> ((r_state == aalr_pkg::S_LINE) && r_emit))
        else $error("first column not queued");

    // a start transfer always begins the setup
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == aalr_pkg::CMD_START)) |=> (r_state == aalr_pkg::S_SWAP))
        else $error("start transfer did not begin setup");
`endif

endmodule

@@ rtl/aalr_dpath.sv @@
// ----------------------------------------------------------------------------
// aalr_dpath
// Endpoint registers, axis swap and ordering, restoring slope divider,
// minor axis accumulator and the column output register.
// ----------------------------------------------------------------------------
module aalr_dpath #(
    parameter int COORD_BITS = aalr_pkg::COORD_BITS,
    parameter int FRAC_BITS  = aalr_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aalr_pkg::t_dp_cmd            i_cmd,
    output aalr_pkg::t_dp_status         o_status,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic signed [COORD_BITS:0]   o_near_x,
    output logic signed [COORD_BITS:0]   o_near_y,
    output logic [7:0]                   o_near_cover,
    output logic signed [COORD_BITS:0]   o_far_x,
    output logic signed [COORD_BITS:0]   o_far_y,
    output logic [7:0]                   o_far_cover,
    output logic                         o_last_column
);

    localparam int D_W = COORD_BITS + 1;              // coordinate difference
    localparam int S_W = FRAC_BITS + 2;               // signed slope
    localparam int A_W = COORD_BITS + FRAC_BITS + 2;  // minor accumulator
    localparam int F_W = COORD_BITS + 2;              // integer part of accumulator

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic                         r_steep;
    logic signed [COORD_BITS-1:0] r_major_pos, r_major_end;
    logic signed [A_W-1:0]        r_minor_acc;
    logic signed [S_W-1:0]        r_slope;
    logic [COORD_BITS-1:0]        r_dx;
    logic [COORD_BITS:0]          r_rem;
    logic [FRAC_BITS:0]           r_quo;
    logic                         r_neg;
    logic                         r_dx_zero;
    logic                         r_last;

    logic signed [COORD_BITS:0]   r_near_x, r_near_y, r_far_x, r_far_y;
    logic [7:0]                   r_near_cover, r_far_cover;
    logic                         r_last_column;

    logic signed [D_W-1:0]        w_dxd, w_dyd, w_adx, w_ady;
    logic                         w_steep, w_rev;
    logic signed [COORD_BITS-1:0] w_minor_start;
    logic [COORD_BITS:0]          w_trial;
    logic                         w_ge;
    logic [FRAC_BITS:0]           w_mag;
    logic signed [S_W-1:0]        w_mag_s;
    logic signed [COORD_BITS-1:0] w_mp_inc;
    logic signed [F_W-1:0]        w_fl, w_fl_p1;
    logic signed [COORD_BITS:0]   w_major_ext;
    logic [FRAC_BITS-1:0]         w_frac;
    logic [FRAC_BITS:0]           w_inv;
    logic [FRAC_BITS+8:0]         w_nc_full;
    logic [FRAC_BITS+7:0]         w_fc_full;

    always_comb begin
        // differences are shared by the swap and order steps
        w_dxd   = $signed({r_bx[COORD_BITS-1], r_bx}) - $signed({r_ax[COORD_BITS-1], r_ax});
        w_dyd   = $signed({r_by[COORD_BITS-1], r_by}) - $signed({r_ay[COORD_BITS-1], r_ay});
        w_adx   = w_dxd[D_W-1] ? -w_dxd : w_dxd;
        w_ady   = w_dyd[D_W-1] ? -w_dyd : w_dyd;
        w_steep = w_ady > w_adx;
        w_rev   = r_ax > r_bx;
        w_minor_start = w_rev ? r_by : r_ay;

        // one restoring division step; remainder stays below dx
        w_trial = i_cmd.div_first ? r_rem : {r_rem[COORD_BITS-1:0], 1'b0};
        w_ge    = w_trial >= {1'b0, r_dx};

        w_mag   = r_dx_zero ? {1'b1, {FRAC_BITS{1'b0}}} : r_quo;
        w_mag_s = $signed({1'b0, w_mag});

        w_mp_inc = r_major_pos + {{(COORD_BITS-1){1'b0}}, 1'b1};

        // floor is the arithmetic top slice of the accumulator
        w_fl        = r_minor_acc[A_W-1:FRAC_BITS];
        w_fl_p1     = w_fl + {{(F_W-1){1'b0}}, 1'b1};
        w_major_ext = {r_major_pos[COORD_BITS-1], r_major_pos};

        // 255 * x as (x << 8) - x
        w_frac    = r_minor_acc[FRAC_BITS-1:0];
        w_inv     = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, w_frac};
        w_nc_full = {w_inv, 8'b0} - {8'b0, w_inv};
        w_fc_full = {w_frac, 8'b0} - {8'b0, w_frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else if (i_cmd.order) begin
            r_last <= (w_adx == '0);
        end else if (i_cmd.advance) begin
            r_last <= w_mp_inc >= r_major_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax <= i_start_x;
            r_ay <= i_start_y;
            r_bx <= i_end_x;
            r_by <= i_end_y;
        end
        if (i_cmd.swap) begin
            r_steep <= w_steep;
            if (w_steep) begin
                r_ax <= r_ay;
                r_ay <= r_ax;
                r_bx <= r_by;
                r_by <= r_bx;
            end
        end
        if (i_cmd.order) begin
            r_major_pos <= w_rev ? r_bx : r_ax;
            r_major_end <= w_rev ? r_ax : r_bx;
            r_minor_acc <= {{2{w_minor_start[COORD_BITS-1]}}, w_minor_start,
                            {FRAC_BITS{1'b0}}};
            r_dx        <= w_adx[COORD_BITS-1:0];
            r_rem       <= {1'b0, w_ady[COORD_BITS-1:0]};
            r_neg       <= w_dyd[D_W-1] ^ w_rev;
            r_dx_zero   <= (w_adx == '0);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_dx}) : w_trial;
            r_quo <= {r_quo[FRAC_BITS-1:0], w_ge};
        end
        if (i_cmd.set_slope) begin
            r_slope <= r_neg ? -w_mag_s : w_mag_s;
        end
        if (i_cmd.advance) begin
            r_major_pos <= w_mp_inc;
            r_minor_acc <= r_minor_acc + {{(A_W-S_W){r_slope[S_W-1]}}, r_slope};
        end
        if (i_cmd.load_out) begin
            if (r_steep) begin
                r_near_x <= w_fl[COORD_BITS:0];
                r_near_y <= w_major_ext;
                r_far_x  <= w_fl_p1[COORD_BITS:0];
                r_far_y  <= w_major_ext;
            end else begin
                r_near_x <= w_major_ext;
                r_near_y <= w_fl[COORD_BITS:0];
                r_far_x  <= w_major_ext;
                r_far_y  <= w_fl_p1[COORD_BITS:0];
            end
            r_near_cover  <= w_nc_full[FRAC_BITS+7:FRAC_BITS];
            r_far_cover   <= w_fc_full[FRAC_BITS+7:FRAC_BITS];
            r_last_column <= r_last;
        end
    end

    assign o_status.last = r_last;
    assign o_near_x      = r_near_x;
    assign o_near_y      = r_near_y;
    assign o_near_cover  = r_near_cover;
    assign o_far_x       = r_far_x;
    assign o_far_y       = r_far_y;
    assign o_far_cover   = r_far_cover;
    assign o_last_column = r_last_column;

endmodule

@@ rtl/antialiased_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Antialiased line stepper: one pixel pair with coverages per column.
//
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_ready   | i_command, endpoints
// output  | out       | o_out_valid / i_out_ready | near/far pixel, covers, last
//
// Start: swap and order setup steps, then the radix-2 restoring slope
// divider (one quotient bit per cycle), then the first column. Advance: one
// column per cycle from the accumulator add unless the output stalls.
// Reset is synchronous, active low, and leaves no line active.
// A stalled output holds one column; one more may be queued behind it.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer #(
    parameter int COORD_BITS = aalr_pkg::COORD_BITS,
    parameter int FRAC_BITS  = aalr_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS:0]   o_near_x,
    output logic signed [COORD_BITS:0]   o_near_y,
    output logic [7:0]                   o_near_cover,
    output logic signed [COORD_BITS:0]   o_far_x,
    output logic signed [COORD_BITS:0]   o_far_y,
    output logic [7:0]                   o_far_cover,
    output logic                         o_last_column
);

    aalr_pkg::t_dp_cmd    w_cmd;
    aalr_pkg::t_dp_status w_status;

    aalr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    aalr_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .o_near_x      (o_near_x),
        .o_near_y      (o_near_y),
        .o_near_cover  (o_near_cover),
        .o_far_x       (o_far_x),
        .o_far_y       (o_far_y),
        .o_far_cover   (o_far_cover),
        .o_last_column (o_last_column)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the antialiased line stepper. A short table of
// directed lines comes first, then random line sequences mixed with idle
// advances and abandoned lines. Both sides idle at random, and the output
// stalls once for a long stretch. Each column transfer is checked against a
// behavioural line stepper run on each input transfer, or a typed column.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COORD_BITS   = aalr_pkg::COORD_BITS;
    localparam int FRAC_BITS    = aalr_pkg::FRAC_BITS;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1450;
    localparam int IDLE_PCT     = 29;
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 800;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * (FRAC_BITS + 5);
    localparam int LIMIT_CYCLES = 400000;
    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));

    localparam longint ONE_FX    = longint'(1) << FRAC_BITS;
    localparam longint FRAC_MASK = ONE_FX - 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic signed [COORD_BITS:0] near_x;
        logic signed [COORD_BITS:0] near_y;
        logic [7:0]                 near_cover;
        logic signed [COORD_BITS:0] far_x;
        logic signed [COORD_BITS:0] far_y;
        logic [7:0]                 far_cover;
        logic                       last_column;
    } t_column;

    typedef struct {
        logic    cmd;
        t_coord  sx;
        t_coord  sy;
        t_coord  ex;
        t_coord  ey;
        bit      typed;
        t_column col;
    } t_stim_row;

    localparam t_column NO_COLUMN = '0;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_ready;
    logic                       i_command    = aalr_pkg::CMD_START;
    t_coord                     i_start_x    = '0;
    t_coord                     i_start_y    = '0;
    t_coord                     i_end_x      = '0;
    t_coord                     i_end_y      = '0;
    logic                       o_out_valid;
    logic                       i_out_ready  = 1'b0;
    logic signed [COORD_BITS:0] o_near_x;
    logic signed [COORD_BITS:0] o_near_y;
    logic [7:0]                 o_near_cover;
    logic signed [COORD_BITS:0] o_far_x;
    logic signed [COORD_BITS:0] o_far_y;
    logic [7:0]                 o_far_cover;
    logic                       o_last_column;

    antialiased_line_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_near_x      (o_near_x),
        .o_near_y      (o_near_y),
        .o_near_cover  (o_near_cover),
        .o_far_x       (o_far_x),
        .o_far_y       (o_far_y),
        .o_far_cover   (o_far_cover),
        .o_last_column (o_last_column)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // behavioural line stepper state
    bit     ln_active    = 1'b0;
    bit     ln_steep     = 1'b0;
    longint ln_major     = 0;
    longint ln_major_end = 0;
    longint ln_minor_fx  = 0;
    longint ln_gradient  = 0;

    t_column   column_fifo[$];
    t_stim_row stim_table[$];
    int        items_sent   = 0;
    int        columns_seen = 0;
    int        err_count    = 0;
    bit        held         = 1'b0;
    logic      quiet_phase;

    assign quiet_phase = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);

    function automatic t_column current_column();
        longint  fl, frac, nx, ny, fx, fy;
        t_column c;
        fl   = ln_minor_fx >>> FRAC_BITS;
        frac = ln_minor_fx & FRAC_MASK;
        if (ln_steep) begin
            nx = fl;       ny = ln_major;
            fx = fl + 1;   fy = ln_major;
        end else begin
            nx = ln_major; ny = fl;
            fx = ln_major; fy = fl + 1;
        end
        c.near_x      = nx[COORD_BITS:0];
        c.near_y      = ny[COORD_BITS:0];
        c.far_x       = fx[COORD_BITS:0];
        c.far_y       = fy[COORD_BITS:0];
        c.near_cover  = 8'((255 * (ONE_FX - frac)) >> FRAC_BITS);
        c.far_cover   = 8'((255 * frac) >> FRAC_BITS);
        c.last_column = (ln_major >= ln_major_end);
        if (c.last_column)
            ln_active = 1'b0;
        return c;
    endfunction

    // returns 1 when the item yields a column
    function automatic bit step_line(input logic cmd, input t_coord sx, sy, ex, ey,
                                     output t_column c);
        longint ax, ay, bx, by, t, dx, dy;
        ax = sx; ay = sy; bx = ex; by = ey;
        c  = NO_COLUMN;
        if (cmd == aalr_pkg::CMD_START) begin
            ln_steep = ((by > ay ? by - ay : ay - by) > (bx > ax ? bx - ax : ax - bx));
            if (ln_steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            ln_gradient  = (dx == 0) ? ONE_FX : (dy * ONE_FX) / dx;
            ln_major     = ax;
            ln_major_end = bx;
            ln_minor_fx  = ay * ONE_FX;
            ln_active    = 1'b1;
            c = current_column();
            return 1'b1;
        end
        if (!ln_active)
            return 1'b0;
        ln_major    = ln_major + 1;
        ln_minor_fx = ln_minor_fx + ln_gradient;
        c = current_column();
        return 1'b1;
    endfunction

    function automatic t_coord shift_coord(input t_coord base, input int delta);
        int moved;
        moved = base + delta;
        if (moved > COORD_MAX || moved < COORD_MIN)
            moved = base - delta;
        return t_coord'(moved);
    endfunction

    function automatic void add_row(input logic cmd, input int sx, sy, ex, ey);
        stim_table.push_back('{cmd, t_coord'(sx), t_coord'(sy), t_coord'(ex),
                               t_coord'(ey), 1'b0, NO_COLUMN});
    endfunction

    function automatic void add_typed(input logic cmd, input int sx, sy, ex, ey,
                                      input int nx, ny, nc, fx, fy, fc, last);
        t_column c;
        c.near_x      = nx[COORD_BITS:0];
        c.near_y      = ny[COORD_BITS:0];
        c.near_cover  = nc[7:0];
        c.far_x       = fx[COORD_BITS:0];
        c.far_y       = fy[COORD_BITS:0];
        c.far_cover   = fc[7:0];
        c.last_column = last[0];
        stim_table.push_back('{cmd, t_coord'(sx), t_coord'(sy), t_coord'(ex),
                               t_coord'(ey), 1'b1, c});
    endfunction

    function automatic string col_text(input t_column c);
        return $sformatf("near (%0d,%0d) %0d far (%0d,%0d) %0d last %0b",
                         c.near_x, c.near_y, c.near_cover,
                         c.far_x, c.far_y, c.far_cover, c.last_column);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    // one input transfer; the stepper runs at the edge the transfer happens
    task automatic push_item(input logic cmd, input t_coord sx, sy, ex, ey,
                             input bit typed, input t_column typed_col);
        t_column c;
        while (!quiet_phase && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (step_line(cmd, sx, sy, ex, ey, c))
            column_fifo.push_back(typed ? typed_col : c);
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= quiet_phase || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_column got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_near_x, o_near_y, o_near_cover, o_far_x, o_far_y, o_far_cover,
                    o_last_column};
            columns_seen++;
            if (column_fifo.size() == 0) begin
                flag_error({"unexpected column: ", col_text(got)});
            end else begin
                want = column_fifo.pop_front();
                if (got !== want)
                    flag_error($sformatf("column %0d: got %s, want %s", columns_seen,
                                         col_text(got), col_text(want)));
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_coord sx, sy, ex, ey;
        int     span, major_d, minor_d, steps, pick;
        bit     along_x;

        // advance while idle, single point, full-width lines, steep line
        add_row(aalr_pkg::CMD_ADVANCE, 32767, -32768, 32767, -32768);
        add_typed(aalr_pkg::CMD_START, 0, 0, 0, 0,  0, 0, 255, 0, 1, 0, 1);
        add_row(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        add_typed(aalr_pkg::CMD_START, -32768, -32768, 32767, -32768,
                  -32768, -32768, 255, -32768, -32767, 0, 0);
        add_typed(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0,
                  -32767, -32768, 255, -32767, -32767, 0, 0);
        // start while busy abandons the horizontal line
        add_typed(aalr_pkg::CMD_START, 32767, 32767, -32768, -32768,
                  -32768, -32768, 255, -32768, -32767, 0, 0);
        add_typed(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0,
                  -32767, -32767, 255, -32767, -32766, 0, 0);
        add_typed(aalr_pkg::CMD_START, 5, 0, 5, 10,  5, 0, 255, 6, 0, 0, 0);
        add_row(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        add_typed(aalr_pkg::CMD_START, 100, -200, 100, -200,
                  100, -200, 255, 100, -199, 0, 1);
        // fractional gradient run to its end, then one more advance while idle
        add_row(aalr_pkg::CMD_START, 0, 0, 3, 1);
        repeat (4) add_row(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        add_row(aalr_pkg::CMD_START, 10, 3, 0, -2);
        repeat (2) add_row(aalr_pkg::CMD_ADVANCE, -1, -1, -1, -1);
        add_row(aalr_pkg::CMD_START, 3, 10, -1, -20);
        repeat (3) add_row(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        add_row(aalr_pkg::CMD_START, 32767, -32768, -32768, 32767);
        repeat (2) add_row(aalr_pkg::CMD_ADVANCE, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k])
            push_item(stim_table[k].cmd, stim_table[k].sx, stim_table[k].sy,
                      stim_table[k].ex, stim_table[k].ey, stim_table[k].typed,
                      stim_table[k].col);

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                // short lines mostly, the odd long one
                span    = ($urandom_range(99) < 6) ? $urandom_range(200) : $urandom_range(12);
                major_d = $urandom_range(1) ? span : -span;
                minor_d = int'($urandom_range(2 * span)) - span;
                along_x = $urandom_range(1);
                sx = t_coord'($urandom);
                sy = t_coord'($urandom);
                ex = shift_coord(sx, along_x ? major_d : minor_d);
                ey = shift_coord(sy, along_x ? minor_d : major_d);
                pick = $urandom_range(99);
                if (pick < 75)
                    steps = span;
                else if (pick < 88)
                    steps = $urandom_range(span);
                else
                    steps = span + $urandom_range(3, 1);
                push_item(aalr_pkg::CMD_START, sx, sy, ex, ey, 1'b0, NO_COLUMN);
                repeat (steps)
                    push_item(aalr_pkg::CMD_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                              t_coord'($urandom), t_coord'($urandom), 1'b0, NO_COLUMN);
            end else if (pick < 90) begin
                push_item(aalr_pkg::CMD_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                          t_coord'($urandom), t_coord'($urandom), 1'b0, NO_COLUMN);
            end else begin
                // wide random line, left unfinished
                push_item(aalr_pkg::CMD_START, t_coord'($urandom), t_coord'($urandom),
                          t_coord'($urandom), t_coord'($urandom), 1'b0, NO_COLUMN);
                repeat ($urandom_range(4))
                    push_item(aalr_pkg::CMD_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                              t_coord'($urandom), t_coord'($urandom), 1'b0, NO_COLUMN);
            end
        end
        i_in_valid <= 1'b0;

        while (column_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ antialiased_line_rasterizer.f @@
rtl/aalr_pkg.sv
rtl/aalr_ctrl.sv
rtl/aalr_dpath.sv
rtl/antialiased_line_rasterizer.sv
tb/sv/testbench.sv
